// ===== hdl/ubf_pkg.sv =====
// shared types, constants and the character table for the base32 id formatter
// no dependencies

package ubf_pkg;

	localparam int WORD_W   = 32;
	localparam int DIGIT_W  = 5;
	localparam int CODE_W   = 7;
	localparam int CSUM_W   = 22;
	localparam int SEQ_W    = 4 * WORD_W + CSUM_W;
	localparam int CSUM_SHR = 10;
	localparam int GROUPS   = 30;
	localparam int GRP_W    = $clog2(GROUPS);
	localparam int PER_DASH = 5;
	localparam int SUB_W    = $clog2(PER_DASH);

	localparam logic [1:0]        LAST_INDEX = 2'd3;
	localparam logic [CODE_W-1:0] DASH_CODE  = 7'h2d;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAR,
		ST_DASH
	} ubf_state_t;

	// handshake between the emitter and the bit store
	typedef struct packed {
		logic load;
		logic shift;
	} ubf_ctrl_t;

	localparam logic [CODE_W-1:0] GLYPHS [32] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h44, 7'h46, 7'h47, 7'h48,
		7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h50, 7'h51, 7'h52,
		7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5a
	};

	function automatic logic [CODE_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
		return GLYPHS[digit];
	endfunction

endpackage

// ===== hdl/ubf_store.sv =====
// id word store, checksum and the 5-bit digit shift register
// uses ubf_pkg

module ubf_store
	import ubf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          word_index,
	input  logic [WORD_W-1:0]   id_word,
	input  ubf_ctrl_t           ctrl,
	output logic [DIGIT_W-1:0]  digit,
	output logic                id_valid
);

	logic [WORD_W-1:0] id_q [4];
	logic [WORD_W-1:0] w [4];
	logic [WORD_W-1:0] xsum;
	logic [WORD_W-1:0] csum;
	logic [SEQ_W-1:0]  seq_q;
	logic              valid_q;

	// current word overrides its stored copy so word 3 counts at once
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			w[i] = (wr_en && word_index == 2'(i)) ? id_word : id_q[i];
		end
		xsum = w[0] ^ w[1] ^ w[2] ^ w[3];
		csum = xsum ^ (xsum >> CSUM_SHR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				id_q[i] <= '0;
			end
		end else if (wr_en) begin
			id_q[word_index] <= id_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			seq_q   <= {csum[CSUM_W-1:0], w[3], w[2], w[1], w[0]};
			valid_q <= |{w[3], w[2], w[1], w[0]};
		end else if (ctrl.shift) begin
			seq_q <= seq_q >> DIGIT_W;
		end
	end

	assign digit    = seq_q[DIGIT_W-1:0];
	assign id_valid = valid_q;

endmodule

// ===== hdl/ubf_emit.sv =====
// character sequencer: groups, dashes and the output register
// uses ubf_pkg

module ubf_emit
	import ubf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIGIT_W-1:0]  digit,
	input  logic                id_valid_in,
	output ubf_ctrl_t           ctrl,
	output logic                idle,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   char_code,
	output logic                last_char,
	output logic                id_valid
);

	ubf_state_t        state_q, state_d;
	logic [GRP_W-1:0]  grp_q, grp_d;
	logic [SUB_W-1:0]  sub_q, sub_d;
	logic              advance;
	logic [CODE_W-1:0] code_nxt;
	logic              last_nxt;
	logic              out_valid_q;
	logic [CODE_W-1:0] char_q;
	logic              last_q;
	logic              idv_q;

	assign advance = (state_q != ST_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		grp_d      = grp_q;
		sub_d      = sub_q;
		code_nxt   = DASH_CODE;
		last_nxt   = 1'b0;
		ctrl.load  = 1'b0;
		ctrl.shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					grp_d     = '0;
					sub_d     = '0;
					state_d   = ST_CHAR;
				end
			end
			ST_CHAR: begin
				code_nxt = glyph(digit);
				last_nxt = (grp_q == GRP_W'(GROUPS - 1));
				if (advance) begin
					ctrl.shift = 1'b1;
					grp_d      = grp_q + 1'b1;
					if (last_nxt) begin
						state_d = ST_IDLE;
					end else if (sub_q == SUB_W'(PER_DASH - 1)) begin
						sub_d   = '0;
						state_d = ST_DASH;
					end else begin
						sub_d = sub_q + 1'b1;
					end
				end
			end
			ST_DASH: begin
				if (advance) begin
					state_d = ST_CHAR;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			sub_q   <= sub_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= code_nxt;
			last_q <= last_nxt;
			idv_q  <= id_valid_in;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign id_valid  = idv_q;

endmodule

// ===== hdl/unique_id_base32_formatter_top.sv =====
// top level of the base32 id formatter
// uses ubf_pkg, ubf_store and ubf_emit
//
// usage:
//   the input channel takes one 32-bit id word per accepted word, tagged with
//   word_index. words 0 to 2 are stored and give no output.
//   word 3 is stored and starts a run of 35 output words: 30 characters of
//   the 0-9/A-Z alphabet without C, E, I, O, with a dash after every fifth
//   character but the last; last_char marks the final one, id_valid says the
//   id is non-zero.
//   on word 3 the bit store loads and the sequencer leaves idle; the first
//   character then enters the output register. with out_ready held high one
//   character is sent per cycle, each non-dash one shifting out a 5-bit digit.
//   in_ready is low while a run is in progress and rises as the final
//   character enters the output register, so a new id can load while it
//   waits to be taken.
//   a low out_ready holds the output register and the sequencer in place;
//   nothing is dropped.
//   reset clears the stored id words to zero and leaves the block idle with
//   no output valid.

module unique_id_base32_formatter_top
	import ubf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          word_index,
	input  logic [WORD_W-1:0]   id_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   char_code,
	output logic                last_char,
	output logic                id_valid
);

	ubf_ctrl_t          ctrl;
	logic               idle;
	logic               wr_en;
	logic               start;
	logic [DIGIT_W-1:0] digit;
	logic               store_valid;

	assign in_ready = idle;
	assign wr_en    = in_valid && idle;
	assign start    = wr_en && (word_index == LAST_INDEX);

	ubf_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.word_index (word_index),
		.id_word    (id_word),
		.ctrl       (ctrl),
		.digit      (digit),
		.id_valid   (store_valid)
	);

	ubf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.digit       (digit),
		.id_valid_in (store_valid),
		.ctrl        (ctrl),
		.idle        (idle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_code   (char_code),
		.last_char   (last_char),
		.id_valid    (id_valid)
	);

	// the final word of a run is a character, never a dash
	a_last_not_dash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> char_code != DASH_CODE)
		else $error("last word of a run is a dash");

	// word 3 starts a run, so input closes on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && word_index == LAST_INDEX |=> !in_ready)
		else $error("input still open after run start");

	// loading and shifting the bit store never coincide
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load && ctrl.shift))
		else $error("bit store load and shift together");

	// a dash is never flagged as the last word of a run
	a_dash_after_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_code == DASH_CODE |-> !last_char)
		else $error("dash flagged as last");

endmodule

// ===== tb/id_string_checker.sv =====
// watches both channels of the base32 id formatter, predicts each id string
// and compares it word by word with what the block sends; uses ubf_pkg

module id_string_checker
	import ubf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        word_index,
	input  logic [WORD_W-1:0] id_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CODE_W-1:0] char_code,
	input  logic              last_char,
	input  logic              id_valid,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// 0-9 and A-Z without C, E, I, O; first character sits in the top byte
	localparam bit [8*32-1:0] ALPHABET = "0123456789ABDFGHJKLMNPQRSTUVWXYZ";
	localparam logic [CODE_W-1:0] HYPHEN = 7'h2d;
	localparam int CHAR_GROUPS = 30;
	localparam int CSUM_BITS = 22;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
		logic              nonzero;
	} id_char_t;

	logic [WORD_W-1:0] id_words [4];
	id_char_t          expected_chars [$];

	task automatic predict_id_string();
		logic [WORD_W-1:0] csum;
		logic [4*WORD_W+CSUM_BITS-1:0] bits;
		logic [4:0] digit;
		logic nonzero;
		id_char_t c;
		int g;
		csum = id_words[0] ^ id_words[1] ^ id_words[2] ^ id_words[3];
		csum = csum ^ (csum >> 10);
		bits = {csum[CSUM_BITS-1:0], id_words[3], id_words[2], id_words[1], id_words[0]};
		nonzero = |{id_words[3], id_words[2], id_words[1], id_words[0]};
		for (g = 0; g < CHAR_GROUPS; g++) begin
			digit = bits[g*5 +: 5];
			c.code = ALPHABET[8*(31-digit) +: CODE_W];
			c.last = (g == CHAR_GROUPS - 1);
			c.nonzero = nonzero;
			expected_chars.push_back(c);
			// dash after every fifth character except the final one
			if (g % 5 == 4 && g != CHAR_GROUPS - 1) begin
				c.code = HYPHEN;
				c.last = 1'b0;
				expected_chars.push_back(c);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		id_char_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				id_words[i] = '0;
			expected_chars.delete();
			errors = 0;
			pending = 0;
		end else begin
			// results go first: a word taken at this edge cannot cause one yet
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					errors++;
					$error("unexpected word: char_code %h last_char %b id_valid %b",
						char_code, last_char, id_valid);
				end else begin
					e = expected_chars.pop_front();
					if (char_code !== e.code) begin
						errors++;
						$error("char_code: expected %h, actual %h", e.code, char_code);
					end
					if (last_char !== e.last) begin
						errors++;
						$error("last_char: expected %b, actual %b", e.last, last_char);
					end
					if (id_valid !== e.nonzero) begin
						errors++;
						$error("id_valid: expected %b, actual %b", e.nonzero, id_valid);
					end
				end
			end
			if (in_valid && in_ready) begin
				id_words[word_index] = id_word;
				if (word_index == LAST_INDEX)
					predict_id_string();
			end
			pending = expected_chars.size();
		end
	end

endmodule

// ===== tb/unique_id_base32_formatter_top_tb.sv =====
// testbench top for the base32 id formatter: clock, reset, id words and
// output back-pressure; checking is left to id_string_checker; uses ubf_pkg

module unique_id_base32_formatter_top_tb
	import ubf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_WORDS = 220;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        word_index = '0;
	logic [WORD_W-1:0] id_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CODE_W-1:0] char_code;
	logic              last_char;
	logic              id_valid;
	int                errors;
	int                pending;

	int send_idle_pct = 29;
	int recv_idle_pct = 58;
	int words_sent = 0;

	unique_id_base32_formatter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.word_index(word_index), .id_word(id_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_code(char_code), .last_char(last_char), .id_valid(id_valid)
	);

	id_string_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.word_index(word_index), .id_word(id_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_code(char_code), .last_char(last_char), .id_valid(id_valid),
		.errors(errors), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input logic [1:0] idx, input logic [WORD_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word_index <= idx;
		id_word <= data;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_id(input logic [WORD_W-1:0] w0, w1, w2, w3);
		send_word(2'd0, w0);
		send_word(2'd1, w1);
		send_word(2'd2, w2);
		send_word(LAST_INDEX, w3);
	endtask

	// hold the input until every predicted character has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(WORD_W-1);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_words(input int upto);
		int n;
		while (words_sent < upto) begin
			case ($urandom_range(9))
				0: send_word(2'($urandom_range(3)), pick_word());
				1: begin
					// partial id that never gets its last word
					n = $urandom_range(1, 3);
					repeat (n) send_word(2'($urandom_range(2)), pick_word());
				end
				2: begin
					// last word alone reuses whatever is stored
					send_word(LAST_INDEX, pick_word());
				end
				default: send_id(pick_word(), pick_word(), pick_word(), pick_word());
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero id straight from reset
		send_word(LAST_INDEX, '0);
		send_id('1, '1, '1, '1);
		send_id(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
		send_word(LAST_INDEX, 32'h0000_0001);
		// out of order and overwritten entries
		send_word(2'd2, 32'h8000_0000);
		send_word(2'd0, '0);
		send_word(2'd0, 32'h0000_0001);
		send_word(2'd1, '0);
		send_word(2'd2, '0);
		send_word(LAST_INDEX, 32'h8000_0000);
		send_id('0, '0, '0, '0);
		random_words(90);

		wait_drained();
		send_idle_pct = 58;
		recv_idle_pct <= 29;
		random_words(160);

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		random_words(TOTAL_WORDS);

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
